// ----- rtl/nges_pkg.sv -----
// Shared types and constants for the next-greater-element stack block.
`timescale 1ns / 1ps
package nges_pkg;

  localparam int unsigned StackDepth = 32;
  localparam int unsigned CountW     = $clog2(StackDepth + 1);
  localparam int unsigned AddrW      = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned DataW      = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    end_of_array;
  } in_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] element;
    logic signed [DataW-1:0] next_greater;
    logic                    found;
    logic                    overflow;
    logic                    last_result;
  } out_req_t;

  typedef enum logic [2:0] {
    StIdle,
    StPopRd,
    StPopCmp,
    StPush,
    StFlRd,
    StFlCmp,
    StFin
  } state_e;

  typedef enum logic [1:0] {
    KindPop,
    KindOvf,
    KindFlush
  } stage_kind_e;

  typedef struct packed {
    logic        in_ready;
    logic        load_in;
    logic        rd_en;
    logic        stage;
    stage_kind_e kind;
    logic        pop;
    logic        push;
    logic        finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic less;
    logic stage_ok;
    logic last;
  } ctrl_sts_t;

endpackage

// ----- rtl/nges_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nges_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/nges_ctrl.sv -----
// Sequencer for pop, push, flush and result hand-off.
`timescale 1ns / 1ps
module nges_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  nges_pkg::ctrl_sts_t sts_i,
  output nges_pkg::ctrl_cmd_t cmd_o
);

  nges_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nges_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nges_pkg::StIdle: begin
        if (in_valid_i) state_d = nges_pkg::StPopRd;
      end
      nges_pkg::StPopRd: begin
        state_d = sts_i.count_zero ? nges_pkg::StPush : nges_pkg::StPopCmp;
      end
      nges_pkg::StPopCmp: begin
        if (!sts_i.less) begin
          state_d = nges_pkg::StPush;
        end else if (sts_i.stage_ok) begin
          state_d = nges_pkg::StPopRd;
        end
      end
      nges_pkg::StPush: begin
        if (!sts_i.count_full || sts_i.stage_ok) begin
          state_d = sts_i.last ? nges_pkg::StFlRd : nges_pkg::StFin;
        end
      end
      nges_pkg::StFlRd: begin
        state_d = sts_i.count_zero ? nges_pkg::StFin : nges_pkg::StFlCmp;
      end
      nges_pkg::StFlCmp: begin
        if (sts_i.stage_ok) state_d = nges_pkg::StFlRd;
      end
      nges_pkg::StFin: begin
        if (sts_i.stage_ok) state_d = nges_pkg::StIdle;
      end
      default: state_d = nges_pkg::StIdle;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    cmd_o.kind = nges_pkg::KindPop;
    unique case (state_q)
      nges_pkg::StIdle: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load_in  = in_valid_i;
      end
      nges_pkg::StPopRd: begin
        cmd_o.rd_en = !sts_i.count_zero;
      end
      nges_pkg::StPopCmp: begin
        if (sts_i.less && sts_i.stage_ok) begin
          cmd_o.stage = 1'b1;
          cmd_o.kind  = nges_pkg::KindPop;
          cmd_o.pop   = 1'b1;
        end
      end
      nges_pkg::StPush: begin
        if (!sts_i.count_full) begin
          cmd_o.push = 1'b1;
        end else if (sts_i.stage_ok) begin
          cmd_o.stage = 1'b1;
          cmd_o.kind  = nges_pkg::KindOvf;
        end
      end
      nges_pkg::StFlRd: begin
        cmd_o.rd_en = !sts_i.count_zero;
      end
      nges_pkg::StFlCmp: begin
        if (sts_i.stage_ok) begin
          cmd_o.stage = 1'b1;
          cmd_o.kind  = nges_pkg::KindFlush;
          cmd_o.pop   = 1'b1;
        end
      end
      nges_pkg::StFin: begin
        cmd_o.finish = sts_i.stage_ok;
      end
      default: cmd_o = '0;
    endcase
  end

  a_one_stack_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.pop && cmd_o.push))
    else $error("pop and push in one cycle");

  a_accept_starts_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_in |=> state_q == nges_pkg::StPopRd)
    else $error("accepted request did not start the pop phase");

  a_no_push_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nges_pkg::StFlCmp) |-> !cmd_o.push)
    else $error("push during flush");

endmodule

// ----- rtl/nges_dpath.sv -----
// Stack memory, count, held result and output register.
`timescale 1ns / 1ps
module nges_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nges_pkg::in_req_t   in_data_i,
  input  nges_pkg::ctrl_cmd_t cmd_i,
  output nges_pkg::ctrl_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output nges_pkg::out_req_t  out_data_o
);

  logic signed [nges_pkg::DataW-1:0] v_q;
  logic                              last_q;
  logic [nges_pkg::CountW-1:0]       count_q, count_d, count_dec;
  logic [nges_pkg::DataW-1:0]        rdata;
  nges_pkg::out_req_t                pend_q, pend_d, out_q, out_d, new_res;
  logic                              pend_vld_q, pend_vld_d, out_vld_q, out_vld_d;
  logic                              out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      v_q    <= in_data_i.value;
      last_q <= in_data_i.end_of_array;
    end
  end

  assign count_dec = count_q - nges_pkg::CountW'(1);

  nges_ram #(
    .Width(nges_pkg::DataW),
    .Depth(nges_pkg::StackDepth)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(count_q[nges_pkg::AddrW-1:0]),
    .wdata_i(v_q),
    .re_i   (cmd_i.rd_en),
    .raddr_i(count_dec[nges_pkg::AddrW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + nges_pkg::CountW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_dec;
    end
  end

  // result for the current step
  always_comb begin
    new_res = '0;
    unique case (cmd_i.kind)
      nges_pkg::KindPop: begin
        new_res.element      = rdata;
        new_res.next_greater = v_q;
        new_res.found        = 1'b1;
      end
      nges_pkg::KindOvf: begin
        new_res.element  = v_q;
        new_res.overflow = 1'b1;
      end
      nges_pkg::KindFlush: begin
        new_res.element = rdata;
      end
      default: new_res = '0;
    endcase
  end

  // one result is held back until it is known whether it is the last
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    if (cmd_i.stage) begin
      if (pend_vld_q) begin
        out_d             = pend_q;
        out_d.last_result = 1'b0;
        out_vld_d         = 1'b1;
      end
      pend_d     = new_res;
      pend_vld_d = 1'b1;
    end else if (cmd_i.finish && pend_vld_q) begin
      out_d             = pend_q;
      out_d.last_result = 1'b1;
      out_vld_d         = 1'b1;
      pend_vld_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      count_q    <= count_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.count_full = (count_q == nges_pkg::CountW'(nges_pkg::StackDepth));
  assign sts_o.less       = ($signed(rdata) < v_q);
  assign sts_o.stage_ok   = !pend_vld_q || out_free;
  assign sts_o.last       = last_q;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= nges_pkg::CountW'(nges_pkg::StackDepth))
    else $error("stack count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> count_q != '0)
    else $error("pop from empty stack");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> count_q == $past(count_q) + nges_pkg::CountW'(1))
    else $error("push did not advance count");

  a_finish_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && pend_vld_q) |=> out_vld_q && out_q.last_result && !pend_vld_q)
    else $error("closing result not flagged last");

endmodule

// ----- rtl/next_greater_element_stack_core.sv -----
// Top level of the next-greater-element monotonic stack block.
`timescale 1ns / 1ps
//
//  channel | signals                           | direction | request
//  --------+-----------------------------------+-----------+---------------------------
//  in      | in_valid_i, in_ready_o, in_data_i | sink      | value, end_of_array
//  out     | out_valid_o, out_ready_i, out_data_o | source | element, next_greater,
//          |                                   |           | found, overflow, last_result
//
//  Each request pops every stacked entry below the new value, pushes the value (or
//  reports overflow when the stack is full) and, on end of array, flushes the rest;
//  the stack memory's registered read puts a read step before each entry's compare.
//  Reset: rst_ni low clears state machine, stack count and output valid; stack memory
//  contents are left as they are and are only read below the count.
//  Stalls: one result is held back until its successor (or the end of the request) is
//  known, so last_result can be set; the output register frees the sequencer while a
//  result waits, and the sequencer waits only when both hold a result and out_ready_i is low.
//  in_ready_o is high only between requests.
module next_greater_element_stack_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nges_pkg::in_req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nges_pkg::out_req_t out_data_o
);

  nges_pkg::ctrl_cmd_t cmd;
  nges_pkg::ctrl_sts_t sts;

  // sequencer: walks pop, push and flush steps for one request
  nges_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath: stack memory, count, compare and result registers
  nges_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  assign in_ready_o = cmd.in_ready;

endmodule
